// ===== sv/sda_pkg.sv =====
// Shared types and constants for the sequence distance accumulator.
`default_nettype none
package sda_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int VEC_BITS      = 40;
  localparam int ROOT_FRAC     = 8;
  localparam int VEC_SHIFT     = 2 * ROOT_FRAC;
  localparam int OUT_BITS      = 48;
  localparam int MODE_BITS     = 2;
  localparam int DIMS_BITS     = 4;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 4;
  localparam int FIFO_DEPTH    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIMS = 1'b1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TOTAL = 2'd0,
    MODE_ABS   = 2'd1,
    MODE_NORMS = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value_a;
    logic signed [SAMPLE_BITS-1:0] value_b;
    logic                          has_a;
    logic                          has_b;
    logic                          last;
  } in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] distance;
    logic                saturated;
  } out_t;

  // one classified element, front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ad;
    mode_e                  mode;
    logic                   close;
    logic                   last;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/sda_front.sv =====
// Front end: configuration, hold registers, element difference and vector bookkeeping.
`default_nettype none
module sda_front #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sda_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [sda_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire sda_pkg::in_t                        in_data_i,
  input  wire logic                                fifo_full_i,
  output logic                                     push_o,
  output sda_pkg::entry_t                          entry_o
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = (sda_pkg::DIMS_BITS > NW) ? sda_pkg::DIMS_BITS : NW;
  localparam int SB = sda_pkg::SAMPLE_BITS;

  logic [sda_pkg::MODE_BITS-1:0] mode_q;
  logic [sda_pkg::DIMS_BITS-1:0] dims_q;
  logic [IW-1:0]                 dim_q, dim_d;
  logic [SB-1:0]                 held_a_q [MAX_DIM];
  logic [SB-1:0]                 held_b_q [MAX_DIM];

  logic [SB-1:0]   a, b;
  logic [SB:0]     diff, mag;
  logic [CW-1:0]   dims_ext, nd, k_next;
  logic            end_vec;
  sda_pkg::mode_e  mode_eff;

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    a = in_data_i.has_a ? in_data_i.value_a : held_a_q[dim_q];
    b = in_data_i.has_b ? in_data_i.value_b : held_b_q[dim_q];
    diff = {a[SB-1], a} - {b[SB-1], b};
    mag  = diff[SB] ? (~diff + {{SB{1'b0}}, 1'b1}) : diff;

    dims_ext = CW'(dims_q);
    if (dims_q == '0) begin
      nd = CW'(1);
    end else if (dims_ext > CW'(MAX_DIM)) begin
      nd = CW'(MAX_DIM);
    end else begin
      nd = dims_ext;
    end
    k_next  = CW'(dim_q) + CW'(1);
    end_vec = (k_next >= nd);
    dim_d   = (end_vec || in_data_i.last) ? '0 : k_next[IW-1:0];

    // mode code 3 acts as total euclidean
    unique case (sda_pkg::mode_e'(mode_q))
      sda_pkg::MODE_ABS:   mode_eff = sda_pkg::MODE_ABS;
      sda_pkg::MODE_NORMS: mode_eff = sda_pkg::MODE_NORMS;
      default:             mode_eff = sda_pkg::MODE_TOTAL;
    endcase

    entry_o.ad    = mag[SB-1:0];
    entry_o.mode  = mode_eff;
    entry_o.close = end_vec || in_data_i.last;
    entry_o.last  = in_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      dims_q <= sda_pkg::DIMS_BITS'(1);
      dim_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sda_pkg::REG_MODE: mode_q <= cfg_data_i[sda_pkg::MODE_BITS-1:0];
          sda_pkg::REG_DIMS: dims_q <= cfg_data_i[sda_pkg::DIMS_BITS-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        dim_q <= dim_d;
      end
    end
  end

  // hold registers: no reset; the user must never fall back on a stale entry, the block does not enforce it
  always_ff @(posedge clk_i) begin
    if (push_o && in_data_i.has_a) begin
      held_a_q[dim_q] <= in_data_i.value_a;
    end
    if (push_o && in_data_i.has_b) begin
      held_b_q[dim_q] <= in_data_i.value_b;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sda_fifo.sv =====
// Small queue of classified elements between front and back.
`default_nettype none
module sda_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sda_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output sda_pkg::entry_t      entry_o
);

  localparam int PW = $clog2(sda_pkg::FIFO_DEPTH);

  sda_pkg::entry_t mem_q [sda_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(sda_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sda_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none
module sda_isqrt #(
  parameter int W = 56
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] radicand_i,
  output logic              done_o,
  output logic [W/2-1:0]    root_o
);

  localparam int HW = W / 2;
  localparam int RW = HW + 2;
  localparam int NW = (HW > 1) ? $clog2(HW) : 1;

  logic          busy_q, done_q;
  logic [NW-1:0] cnt_q;
  logic [W-1:0]  rad_q;
  logic [RW-1:0] rem_q;
  logic [HW-1:0] root_q;

  logic [RW-1:0] rem_next, trial;
  logic          fits;

  assign done_o = done_q;
  assign root_o = root_q;

  always_comb begin
    rem_next = {rem_q[RW-3:0], rad_q[W-1 -: 2]};
    trial    = {root_q, 2'b01};
    fits     = (rem_next >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(HW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_next - trial;
        root_q <= {root_q[HW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_next;
        root_q <= {root_q[HW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sda_back.sv =====
// Back end: squaring, saturating accumulation, root sequencing and result register.
`default_nettype none
module sda_back #(
  parameter int ACC_BITS = 56
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire sda_pkg::entry_t entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sda_pkg::out_t        out_data_o
);

  localparam int SQ   = sda_pkg::SQ_BITS;
  localparam int VB   = sda_pkg::VEC_BITS;
  localparam int OB   = sda_pkg::OUT_BITS;
  localparam int VOPW = VB + sda_pkg::VEC_SHIFT;
  localparam int RMAX = (ACC_BITS > VOPW) ? ACC_BITS : VOPW;
  localparam int SQW  = ((RMAX + 1) / 2) * 2;
  localparam int RTW  = SQW / 2;
  localparam int SW0  = (ACC_BITS > SQ) ? ACC_BITS : SQ;
  localparam int SW   = ((SW0 > RTW) ? SW0 : RTW) + 1;
  localparam int DW   = (ACC_BITS > OB) ? ACC_BITS : OB;

  typedef enum logic [2:0] {
    S_RUN, S_VROOT, S_FIN, S_TROOT, S_EMIT
  } state_e;

  state_e                 state_q;
  logic                   st_valid_q;
  logic [SQ-1:0]          st_sq_q;
  logic [sda_pkg::SAMPLE_BITS-1:0] st_ad_q;
  sda_pkg::mode_e         st_mode_q;
  logic                   st_close_q, st_last_q;
  sda_pkg::mode_e         fin_mode_q;
  logic                   last_pend_q;
  logic [ACC_BITS-1:0]    total_q;
  logic [VB-1:0]          vsum_q;
  logic                   ovf_q;
  logic                   sq_start_q;
  logic [SQW-1:0]         sq_rad_q;
  logic [OB-1:0]          res_q;
  logic                   res_sat_q;
  logic                   out_valid_q;
  sda_pkg::out_t          out_q;

  logic                   sq_done;
  logic [RTW-1:0]         sq_root;
  logic                   special;
  logic [SW-1:0]          addend, tot_sum;
  logic                   tot_sat;
  logic [ACC_BITS-1:0]    tot_new;
  logic [VB:0]            vec_sum;
  logic                   vec_sat;
  logic [VB-1:0]          vsum_new;
  logic [DW-1:0]          fin_val;
  logic                   clamp;
  logic [OB-1:0]          res_d;
  logic                   emit_free;
  logic                   start_vroot, start_troot, emit_fire;

  sda_isqrt #(
    .W (SQW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (sq_rad_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign emit_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    // staged element needs the sequencer: vector norm or a result
    special = st_valid_q &&
              ((st_close_q && (st_mode_q == sda_pkg::MODE_NORMS)) || st_last_q);
    pop_o = (state_q == S_RUN) && !special && !empty_i;

    start_vroot = (state_q == S_RUN) && st_valid_q && st_close_q &&
                  (st_mode_q == sda_pkg::MODE_NORMS);
    start_troot = (state_q == S_FIN) && (fin_mode_q == sda_pkg::MODE_TOTAL);
    emit_fire   = (state_q == S_EMIT) && emit_free;

    if (state_q == S_VROOT) begin
      addend = SW'(sq_root);
    end else begin
      case (st_mode_q)
        sda_pkg::MODE_TOTAL: addend = SW'(st_sq_q);
        sda_pkg::MODE_ABS:   addend = SW'(st_ad_q);
        default:             addend = '0;
      endcase
    end
    tot_sum = SW'(total_q) + addend;
    tot_sat = (tot_sum > SW'({ACC_BITS{1'b1}}));
    tot_new = tot_sat ? {ACC_BITS{1'b1}} : tot_sum[ACC_BITS-1:0];

    vec_sum  = {1'b0, vsum_q} + (VB+1)'(st_sq_q);
    vec_sat  = vec_sum[VB];
    vsum_new = vec_sat ? {VB{1'b1}} : vec_sum[VB-1:0];

    if (state_q == S_TROOT) begin
      fin_val = DW'(sq_root);
    end else if (fin_mode_q == sda_pkg::MODE_ABS) begin
      fin_val = DW'(total_q);
    end else begin
      fin_val = DW'(total_q >> sda_pkg::ROOT_FRAC);
    end
    clamp = (fin_val > DW'({OB{1'b1}}));
    res_d = clamp ? {OB{1'b1}} : fin_val[OB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      st_valid_q  <= 1'b0;
      total_q     <= '0;
      vsum_q      <= '0;
      ovf_q       <= 1'b0;
      sq_start_q  <= 1'b0;
      last_pend_q <= 1'b0;
      fin_mode_q  <= sda_pkg::MODE_TOTAL;
      out_valid_q <= 1'b0;
    end else begin
      sq_start_q <= start_vroot || start_troot;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_RUN: begin
          if (st_valid_q) begin
            total_q <= tot_new;
            vsum_q  <= st_close_q ? '0 : vsum_new;
            if (tot_sat || (vec_sat && (st_mode_q == sda_pkg::MODE_NORMS))) begin
              ovf_q <= 1'b1;
            end
            fin_mode_q  <= st_mode_q;
            last_pend_q <= st_last_q;
            if (st_close_q && (st_mode_q == sda_pkg::MODE_NORMS)) begin
              sq_rad_q   <= SQW'({vsum_new, {sda_pkg::VEC_SHIFT{1'b0}}});
              state_q    <= S_VROOT;
            end else if (st_last_q) begin
              state_q <= S_FIN;
            end
          end
          st_valid_q <= pop_o;
        end
        S_VROOT: begin
          if (sq_done) begin
            total_q <= tot_new;
            if (tot_sat) begin
              ovf_q <= 1'b1;
            end
            state_q <= last_pend_q ? S_FIN : S_RUN;
          end
        end
        S_FIN: begin
          if (fin_mode_q == sda_pkg::MODE_TOTAL) begin
            sq_rad_q   <= SQW'(total_q);
            state_q    <= S_TROOT;
          end else begin
            res_q     <= res_d;
            res_sat_q <= ovf_q || clamp;
            total_q   <= '0;
            ovf_q     <= 1'b0;
            state_q   <= S_EMIT;
          end
        end
        S_TROOT: begin
          if (sq_done) begin
            res_q     <= res_d;
            res_sat_q <= ovf_q || clamp;
            total_q   <= '0;
            ovf_q     <= 1'b0;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_free) begin
            out_q.distance  <= res_q;
            out_q.saturated <= res_sat_q;
            state_q         <= S_RUN;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  // element stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      st_sq_q    <= SQ'(entry_i.ad) * SQ'(entry_i.ad);
      st_ad_q    <= entry_i.ad;
      st_mode_q  <= entry_i.mode;
      st_close_q <= entry_i.close;
      st_last_q  <= entry_i.last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sequence_distance_accumulator_core.sv =====
// Throughput: one element per cycle in the sum modes, but a last element holds the back end
// until its result is emitted; in per-vector norm mode a vector end holds it for a 28-step
// serial root. An accepted element is written into the queue and then into the back end's
// stage register; a result then passes S_FIN, S_TROOT (total mode root) and S_EMIT.
// Reset clears accumulators, queue, output valid and config (mode 0, dims 1);
// hold registers are not reset and are valid once written.
`default_nettype none
module sequence_distance_accumulator_core #(
  parameter int MAX_DIM  = 8,
  parameter int ACC_BITS = 56
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sda_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [sda_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire sda_pkg::in_t                      in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output sda_pkg::out_t                          out_data_o
);

  logic            push, pop, full, empty;
  sda_pkg::entry_t push_entry, pop_entry;

  sda_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sda_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  sda_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_sequence_distance_accumulator_core.sv =====
// Self-checking testbench for the sequence distance accumulator core.
`timescale 1ns / 100ps
module tb_sequence_distance_accumulator_core;

  localparam int MAX_DIM = 8;
  localparam int RANDOM_BEATS = 2000;
  localparam int SETTLE_CYCLES = 200;   // covers several queued roots in norm mode
  localparam int HOLD_CYCLES = 300;
  localparam int SQUEEZE_BEATS = 40;
  // code 3 of the mode register is not an enum member; it decodes as MODE_TOTAL
  localparam logic [sda_pkg::MODE_BITS-1:0] MODE_ALIAS = 2'd3;

  typedef struct packed {
    logic                         cfg;   // row rewrites both registers instead of sending a beat
    logic [1:0]                   mode;
    logic [3:0]                   dims;
    sda_pkg::in_t                 beat;
    logic                         typed; // distance below is known by hand
    logic [sda_pkg::OUT_BITS-1:0] want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [sda_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [sda_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sda_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sda_pkg::out_t out_data;

  always #5 clk_i = ~clk_i;

  sequence_distance_accumulator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // distance predictor state
  logic [1:0]                             cur_mode = sda_pkg::MODE_TOTAL;
  logic [3:0]                             cur_dims = 4'd1;
  logic [55:0]                            acc_total = '0;
  logic [sda_pkg::VEC_BITS-1:0]           acc_vector = '0;
  logic                                   acc_over = 1'b0;
  int unsigned                            slot = 0;
  logic signed [sda_pkg::SAMPLE_BITS-1:0] held_a [MAX_DIM];
  logic signed [sda_pkg::SAMPLE_BITS-1:0] held_b [MAX_DIM];
  bit                                     seen_a [MAX_DIM];
  bit                                     seen_b [MAX_DIM];

  sda_pkg::out_t results_due[$];
  int unsigned beats_sent = 0;
  int unsigned failures = 0;
  bit squeeze_req = 1'b0;

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (32'd1 << i);
      if ({32'd0, cand} * {32'd0, cand} <= x) root = cand;
    end
    return root;
  endfunction

  function automatic int unsigned vector_len();
    if (cur_dims == 0) return 1;
    if (cur_dims > MAX_DIM) return MAX_DIM;
    return cur_dims;
  endfunction

  function automatic void add_to_total(input logic [55:0] v);
    logic [56:0] s;
    s = {1'b0, acc_total} + {1'b0, v};
    if (s[56]) begin
      acc_total = '1;
      acc_over = 1'b1;
    end else begin
      acc_total = s[55:0];
    end
  endfunction

  function automatic void close_vector(input logic [1:0] m);
    if (m == sda_pkg::MODE_NORMS) begin
      add_to_total(56'(floor_root(64'({acc_vector, 16'h0000}))));
    end
    acc_vector = '0;
  endfunction

  // Folds one accepted beat into the predictor; returns 1 when a distance is due.
  function automatic bit accumulate_beat(input sda_pkg::in_t beat, output sda_pkg::out_t res);
    logic [1:0]  m;
    int unsigned nd;
    logic [16:0] diff;
    logic [15:0] ad;
    logic [31:0] sq;
    logic [40:0] vsum;
    logic [55:0] d;
    m = (cur_mode == MODE_ALIAS) ? sda_pkg::MODE_TOTAL : cur_mode;
    nd = vector_len();
    res = '0;
    if (beat.has_a) begin
      held_a[slot] = beat.value_a;
      seen_a[slot] = 1'b1;
    end
    if (beat.has_b) begin
      held_b[slot] = beat.value_b;
      seen_b[slot] = 1'b1;
    end
    diff = {held_a[slot][15], held_a[slot]} - {held_b[slot][15], held_b[slot]};
    ad = diff[16] ? 16'(-diff) : diff[15:0];
    sq = {16'd0, ad} * {16'd0, ad};
    if (m == sda_pkg::MODE_TOTAL) add_to_total(56'(sq));
    else if (m == sda_pkg::MODE_ABS) add_to_total(56'(ad));
    vsum = {1'b0, acc_vector} + 41'(sq);
    if (vsum[40]) begin
      acc_vector = '1;
      if (m == sda_pkg::MODE_NORMS) acc_over = 1'b1;
    end else begin
      acc_vector = vsum[39:0];
    end
    if (slot + 1 >= nd) begin
      close_vector(m);
      slot = 0;
    end else begin
      slot++;
    end
    if (!beat.last) return 1'b0;
    // partial vector still counts in norm mode
    if (slot != 0) close_vector(m);
    case (m)
      sda_pkg::MODE_TOTAL: d = 56'(floor_root(64'(acc_total)));
      sda_pkg::MODE_ABS:   d = acc_total;
      default:             d = acc_total >> sda_pkg::ROOT_FRAC;
    endcase
    res.saturated = acc_over;
    if (d[55:sda_pkg::OUT_BITS] != 0) begin
      res.distance = '1;
      res.saturated = 1'b1;
    end else begin
      res.distance = d[sda_pkg::OUT_BITS-1:0];
    end
    acc_total = '0;
    acc_vector = '0;
    acc_over = 1'b0;
    slot = 0;
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [sda_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] mode, input logic [3:0] dims);
    plan_row_t r;
    r = '0;
    r.cfg = 1'b1;
    r.mode = mode;
    r.dims = dims;
    return r;
  endfunction

  function automatic plan_row_t beat_row(input int a, input int b, input logic ha,
                                         input logic hb, input logic last,
                                         input logic typed = 1'b0,
                                         input logic [sda_pkg::OUT_BITS-1:0] want = '0);
    plan_row_t r;
    r = '0;
    r.beat.value_a = 16'(a);
    r.beat.value_b = 16'(b);
    r.beat.has_a = ha;
    r.beat.has_b = hb;
    r.beat.last = last;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Registers change only once the block has drained.
  task automatic set_config(input logic [1:0] mode, input logic [3:0] dims);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= sda_pkg::REG_MODE;
    cfg_data <= {2'b00, mode};
    @(posedge clk_i);
    cur_mode = mode;
    cfg_index <= sda_pkg::REG_DIMS;
    cfg_data <= dims;
    @(posedge clk_i);
    cur_dims = dims;
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input sda_pkg::in_t beat, input logic typed,
                           input logic [sda_pkg::OUT_BITS-1:0] want, input bit hurry);
    sda_pkg::out_t res;
    bit emit;
    int unsigned gap;
    // never fall back on a hold slot that has not been loaded yet
    if (!seen_a[slot]) beat.has_a = 1'b1;
    if (!seen_b[slot]) beat.has_b = 1'b1;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk_i); while (in_stall);
    emit = accumulate_beat(beat, res);
    if (emit) begin
      if (typed) begin
        res.distance = want;
        res.saturated = 1'b0;
      end
      results_due.push_back(res);
    end
    beats_sent++;
    gap = hurry ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_noise(input logic force_last, input bit hurry);
    sda_pkg::in_t beat;
    beat.value_a = pick_sample();
    beat.value_b = pick_sample();
    beat.has_a = 1'($urandom);
    beat.has_b = 1'($urandom);
    beat.last = force_last || ($urandom_range(0, 7) == 0);
    send_beat(beat, 1'b0, '0, hurry);
  endtask

  // Two series of whole vectors; the shorter one is padded from its hold slots.
  task automatic send_series(input bit hurry);
    int unsigned nd;
    int unsigned len_a;
    int unsigned len_b;
    int unsigned total;
    sda_pkg::in_t beat;
    nd = vector_len();
    len_a = $urandom_range(1, 5) * nd;
    len_b = $urandom_range(1, 5) * nd;
    total = (len_a > len_b) ? len_a : len_b;
    for (int unsigned e = 0; e < total; e++) begin
      beat.value_a = pick_sample();
      beat.value_b = pick_sample();
      beat.has_a = (e < len_a);
      beat.has_b = (e < len_b);
      beat.last = (e == total - 1);
      send_beat(beat, 1'b0, '0, hurry);
    end
  endtask

  initial begin
    plan_row_t plan[$];
    logic [1:0] mode_pick;
    logic [3:0] dims_pick;
    int unsigned r;
    int unsigned quota;
    bit hurry;
    plan = '{
      // reset defaults: total euclidean, one dimension
      beat_row(32767, -32768, 1, 1, 1, 1, 48'd65535),
      beat_row(-32768, 32767, 1, 1, 1, 1, 48'd65535),
      beat_row(0, 0, 1, 1, 1, 1, 48'd0),
      beat_row(-1, -1, 0, 0, 1, 1, 48'd0),        // both series ended
      beat_row(3, -1, 1, 0, 1, 1, 48'd3),         // hold survives a result
      beat_row(5, 4, 0, 1, 1, 1, 48'd1),
      cfg_row(sda_pkg::MODE_ABS, 4'd1),
      beat_row(-32768, 32767, 1, 1, 1, 1, 48'd65535),
      beat_row(100, -5, 1, 1, 0),
      beat_row(-7, 1, 1, 1, 1, 1, 48'd113),
      cfg_row(sda_pkg::MODE_NORMS, 4'd3),
      beat_row(3, 0, 1, 1, 0),
      beat_row(4, 0, 1, 1, 0),
      beat_row(0, 0, 1, 1, 1, 1, 48'd5),
      beat_row(1, 0, 1, 1, 0),
      beat_row(1, 0, 1, 1, 1, 1, 48'd1),          // last lands mid-vector
      cfg_row(MODE_ALIAS, 4'd0),
      beat_row(-32768, 32767, 1, 1, 1, 1, 48'd65535),
      cfg_row(sda_pkg::MODE_TOTAL, 4'd15),        // clamps to the widest vector
      beat_row(32767, -32768, 1, 1, 0),
      beat_row(-32768, 32767, 1, 1, 0),
      beat_row(32767, 32767, 1, 1, 0),
      beat_row(-32768, -32768, 1, 1, 0),
      cfg_row(sda_pkg::MODE_ABS, 4'd15),          // mode switch inside a vector
      beat_row(1, -1, 1, 1, 0),
      beat_row(-1, 1, 1, 1, 0),
      beat_row(32767, 0, 1, 1, 0),
      beat_row(0, -32768, 1, 1, 1),
      cfg_row(sda_pkg::MODE_NORMS, 4'd8),
      beat_row(1, 2, 0, 1, 0),
      beat_row(9, 9, 0, 0, 1)
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg) set_config(plan[i].mode, plan[i].dims);
      else send_beat(plan[i].beat, plan[i].typed, plan[i].want, 1'b0);
    end

    // receiver holds off while every beat asks for a result
    set_config(sda_pkg::MODE_ABS, 4'd1);
    squeeze_req = 1'b1;
    repeat (SQUEEZE_BEATS) send_noise(1'b1, 1'b1);

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      mode_pick = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      if (r < 6) dims_pick = 4'($urandom_range(1, 4));
      else if (r < 8) dims_pick = 4'($urandom_range(5, 8));
      else begin
        r = $urandom_range(0, 7);
        dims_pick = (r == 0) ? 4'd0 : 4'(8 + r);
      end
      set_config(mode_pick, dims_pick);
      hurry = ($urandom_range(0, 5) == 0);
      quota = beats_sent + $urandom_range(20, 80);
      while (beats_sent < quota) begin
        if ($urandom_range(0, 4) != 0) send_series(hurry);
        else send_noise(1'b0, hurry);
      end
      // most phases close their stream; the rest change mode mid-stream
      if ($urandom_range(0, 3) != 0) send_noise(1'b1, hurry);
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // result side backpressure
  initial begin
    int unsigned run;
    bit stall_run;
    run = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        out_stall <= 1'b0;
        run = $urandom_range(20, 60);
      end else if (run != 0) begin
        run--;
      end else begin
        stall_run = ($urandom_range(0, 2) == 0);
        out_stall <= stall_run;
        run = stall_run ? idle_len() : $urandom_range(0, 40);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    sda_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, distance %0d saturated %0b",
                 $time, out_data.distance, out_data.saturated);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (out_data.distance !== want.distance) begin
          $display("%0t: distance expected %0d, got %0d",
                   $time, want.distance, out_data.distance);
          failures++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b, got %0b",
                   $time, want.saturated, out_data.saturated);
          failures++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
